// File: hdl/cascaded_biquad_allpass_chain_unit_macros.svh
// Assertion macros for the cascaded biquad chain.
// Used by the top level; depends on nothing else.
`ifndef CASCADED_BIQUAD_ALLPASS_CHAIN_UNIT_MACROS_SVH
`define CASCADED_BIQUAD_ALLPASS_CHAIN_UNIT_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define CBQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that must also hold during reset.
`define CBQ_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/cbq_pkg.sv
// Package for the cascaded biquad chain: widths, register indexes, state codes.
// Used by cascaded_biquad_allpass_chain_unit; depends on nothing.
package cbq_pkg;
	localparam int STAGES      = 128;
	localparam int SAMPLE_BITS = 12;
	localparam int COEF_BITS   = 20;
	localparam int Y_BITS      = 24;
	localparam int X_BITS      = SAMPLE_BITS + 1;
	localparam int STAGE_BITS  = $clog2(STAGES);
	localparam int ADDR_BITS   = STAGE_BITS + 1;
	localparam int ALIGN_SH    = 21 - SAMPLE_BITS;
	localparam int PROD_BITS   = COEF_BITS + Y_BITS;
	localparam int ACC_BITS    = 50;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int CNT_BITS    = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_FF0    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FF1    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FF2    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FB1    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FB2    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_STAGES = 3'd5;

	// One product term per cycle; the sequencer walks the five taps.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_SAT,
		ST_WB,
		ST_OUT
	} state_t;
endpackage

// File: hdl/cascaded_biquad_allpass_chain_unit.sv
// Cascaded direct-form-I biquad chain, one shared multiply-accumulate unit.
// Each active stage runs a tap read, five multiply-accumulate steps, saturation
// and two tap writes. A new sample is taken only when the chain is idle;
// a waiting result holds only the finish.
// Reset restores default coefficients; a count of stages written since reset
// makes never-written taps read as zero. Depends on cbq_pkg and the macros header.
`include "cascaded_biquad_allpass_chain_unit_macros.svh"
module cascaded_biquad_allpass_chain_unit
	import cbq_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_BITS-1:0]        sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [SAMPLE_BITS-1:0]        sample_out,
	output logic                          clipped,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);
	localparam int NWORDS = 2 * STAGES;

	state_t state_q, state_d;
	logic signed [COEF_BITS-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
	logic [CNT_BITS-1:0] nstg_q;
	logic [STAGE_BITS-1:0] stg_q;
	logic [STAGE_BITS:0] last_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic clip_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic res_clip_q, res_valid_q;

	// Tap memories; stages below the fill count have been written since reset.
	logic [X_BITS-1:0] xmem [NWORDS];
	logic [Y_BITS-1:0] ymem [NWORDS];
	logic [STAGE_BITS:0] fill_q;
	logic tap_ok;
	logic [X_BITS-1:0] xrd_q;
	logic [Y_BITS-1:0] yrd_q;
	logic [ADDR_BITS-1:0] raddr;
	logic rd_en, wr_en;
	logic [ADDR_BITS-1:0] waddr;
	logic [X_BITS-1:0] wx;
	logic [Y_BITS-1:0] wy;

	logic signed [X_BITS-1:0] x0_q, x1_q, x2_q;
	logic signed [Y_BITS-1:0] y1_q, y2_q, ynew_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic wb_phase_q;

	// Shared multiplier operands.
	logic signed [COEF_BITS-1:0] mc;
	logic signed [Y_BITS-1:0] md;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [ACC_BITS-1:0] prod_ext, acc_next;
	logic add_sub;

	logic signed [X_BITS-1:0] x0_new;
	logic signed [ACC_BITS-1:0] yfull;
	logic signed [Y_BITS-1:0] ysat;
	logic ysat_clip;
	logic signed [Y_BITS-ALIGN_SH-1:0] qs;
	logic signed [Y_BITS-ALIGN_SH:0] qoff;
	logic [SAMPLE_BITS-1:0] qsamp;
	logic qclip;

	assign cfg_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = res_valid_q;
	assign sample_out = res_q;
	assign clipped   = res_clip_q;
	assign tap_ok    = ({1'b0, stg_q} < fill_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff0_q  <= 20'sd46395;
			ff1_q  <= -20'sd105181;
			ff2_q  <= 20'sd65536;
			fb1_q  <= -20'sd105181;
			fb2_q  <= 20'sd46395;
			nstg_q <= CNT_BITS'(STAGES);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FF0:    ff0_q  <= cfg_data[COEF_BITS-1:0];
				REG_FF1:    ff1_q  <= cfg_data[COEF_BITS-1:0];
				REG_FF2:    ff2_q  <= cfg_data[COEF_BITS-1:0];
				REG_FB1:    fb1_q  <= cfg_data[COEF_BITS-1:0];
				REG_FB2:    fb2_q  <= cfg_data[COEF_BITS-1:0];
				REG_STAGES: nstg_q <= cfg_data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Multiplier operand selection and accumulate.
	always_comb begin
		mc = ff0_q;
		md = Y_BITS'(x0_q);
		add_sub = 1'b0;
		case (state_q)
			ST_M0: begin mc = ff0_q; md = Y_BITS'(x0_q); end
			ST_M1: begin mc = ff1_q; md = Y_BITS'(x1_q); end
			ST_M2: begin mc = ff2_q; md = Y_BITS'(x2_q); end
			ST_M3: begin mc = fb1_q; md = y1_q; add_sub = 1'b1; end
			ST_M4: begin mc = fb2_q; md = y2_q; add_sub = 1'b1; end
			default: ;
		endcase
		prod = mc * md;
		// Feed-forward terms carry the alignment shift of the input scale.
		if (add_sub) prod_ext = ACC_BITS'(prod);
		else prod_ext = ACC_BITS'(prod) <<< ALIGN_SH;
		acc_next = add_sub ? acc_q - prod_ext : acc_q + prod_ext;
	end

	// Saturation and requantization of the stage output.
	always_comb begin
		x0_new = $signed({1'b0, sample_q}) - $signed(X_BITS'(1 << (SAMPLE_BITS-1)));
		yfull = acc_q >>> 16;
		ysat_clip = 1'b0;
		if (yfull > ACC_BITS'(signed'(Y_BITS'({1'b0, {(Y_BITS-1){1'b1}}})))) begin
			ysat = {1'b0, {(Y_BITS-1){1'b1}}};
			ysat_clip = 1'b1;
		end else if (yfull < -(ACC_BITS'(1) <<< (Y_BITS-1))) begin
			ysat = {1'b1, {(Y_BITS-1){1'b0}}};
			ysat_clip = 1'b1;
		end else begin
			ysat = yfull[Y_BITS-1:0];
		end
		qs = ynew_q[Y_BITS-1:ALIGN_SH];
		qoff = (Y_BITS-ALIGN_SH+1)'(qs) + (Y_BITS-ALIGN_SH+1)'(1 << (SAMPLE_BITS-1));
		qclip = 1'b0;
		if (qoff < 0) begin
			qsamp = '0;
			qclip = 1'b1;
		end else if (qoff > (Y_BITS-ALIGN_SH+1)'((1 << SAMPLE_BITS) - 1)) begin
			qsamp = '1;
			qclip = 1'b1;
		end else begin
			qsamp = qoff[SAMPLE_BITS-1:0];
		end
	end

	// Sequencer next state and memory control.
	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		raddr = {stg_q, 1'b0};
		wr_en = 1'b0;
		waddr = {stg_q, wb_phase_q};
		wx = wb_phase_q ? x1_q : x0_q;
		wy = wb_phase_q ? y1_q : ynew_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && !in_stall) state_d = ST_RD;
			ST_RD: begin
				rd_en = 1'b1;
				raddr = {stg_q, 1'b0};
				state_d = ST_M0;
			end
			ST_M0: begin
				rd_en = 1'b1;
				raddr = {stg_q, 1'b1};
				state_d = ST_M1;
			end
			ST_M1: state_d = ST_M2;
			ST_M2: state_d = ST_M3;
			ST_M3: state_d = ST_M4;
			ST_M4: state_d = ST_SAT;
			ST_SAT: state_d = ST_WB;
			ST_WB: begin
				wr_en = 1'b1;
				if (wb_phase_q) begin
					if ({1'b0, stg_q} == last_q) state_d = ST_OUT;
					else state_d = ST_RD;
				end
			end
			// The finished item waits here while the previous result is held.
			ST_OUT: if (!(res_valid_q && out_stall)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Tap memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			xmem[waddr] <= wx;
			ymem[waddr] <= wy;
		end
		if (rd_en) begin
			xrd_q <= xmem[raddr];
			yrd_q <= ymem[raddr];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid && !in_stall) sample_q <= sample_in;
			ST_RD: begin
				x0_q <= x0_new;
				acc_q <= '0;
			end
			ST_M0: begin
				acc_q <= acc_next;
				x1_q <= tap_ok ? xrd_q : '0;
				y1_q <= tap_ok ? yrd_q : '0;
			end
			ST_M1: begin
				acc_q <= acc_next;
				x2_q <= tap_ok ? xrd_q : '0;
				y2_q <= tap_ok ? yrd_q : '0;
			end
			ST_M2, ST_M3, ST_M4: acc_q <= acc_next;
			ST_SAT: ynew_q <= ysat;
			ST_WB: if (!wb_phase_q) sample_q <= qsamp;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stg_q <= '0;
			last_q <= '0;
			clip_q <= 1'b0;
			wb_phase_q <= 1'b0;
			fill_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
			res_clip_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && !(res_valid_q && out_stall)) begin
				res_valid_q <= 1'b1;
				res_q <= sample_q;
				res_clip_q <= clip_q;
			end else if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid && !in_stall) begin
					stg_q <= '0;
					clip_q <= 1'b0;
					wb_phase_q <= 1'b0;
					if (nstg_q == '0) last_q <= '0;
					else if (32'(nstg_q) > STAGES) last_q <= (STAGE_BITS+1)'(STAGES - 1);
					else last_q <= (STAGE_BITS+1)'(nstg_q - 1'b1);
				end
				ST_SAT: if (ysat_clip) clip_q <= 1'b1;
				ST_WB: begin
					wb_phase_q <= !wb_phase_q;
					if (!wb_phase_q) begin
						if (qclip) clip_q <= 1'b1;
					end else begin
						if ({1'b0, stg_q} == fill_q) fill_q <= fill_q + 1'b1;
						if ({1'b0, stg_q} != last_q) stg_q <= stg_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	`CBQ_ASSERT(a_no_accept_busy, clk, arst_n, (state_q != ST_IDLE) |-> in_stall, "accepted while busy")
	`CBQ_ASSERT(a_out_after_done, clk, arst_n, $rose(res_valid_q) |-> $past(state_q == ST_OUT), "result without finish")
	`CBQ_ASSERT(a_stage_bound, clk, arst_n, (state_q != ST_IDLE) |-> ({1'b0, stg_q} <= last_q), "stage past last")
	`CBQ_ASSERT_ALWAYS(a_cfg_idle, clk, cfg_ready |-> (state_q == ST_IDLE), "config while busy")
endmodule

// File: sim/cascaded_biquad_allpass_chain_unit_tb.sv
// Self-checking testbench for the cascaded biquad chain: a driver and a monitor,
// a built-in predictor of the stage arithmetic, and several idling phases.
// Depends on cbq_pkg and the cascaded_biquad_allpass_chain_unit RTL.
`timescale 1ns / 1ps
module cascaded_biquad_allpass_chain_unit_tb;
	import cbq_pkg::*;

	typedef struct {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   clip;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SAMPLE_BITS-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	cascaded_biquad_allpass_chain_unit dut (.*);

	always #5 clk = ~clk;

	// Predictor state: coefficients, stage count and per-stage taps.
	longint ff0, ff1, ff2, fb1, fb2;
	int unsigned stage_count;
	longint x_tap1 [STAGES], x_tap2 [STAGES], y_tap1 [STAGES], y_tap2 [STAGES];

	logic [SAMPLE_BITS-1:0] pending_samples [$];
	filtered_t expected_filtered [$];
	int unsigned send_idle_pct = 0, recv_stall_pct = 0;
	bit failed = 1'b0;

	// Floor division by a power of two; the shift operator on longint is arithmetic.
	function automatic longint floor_shr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint sext20(logic [31:0] v);
		return longint'(signed'(v[19:0]));
	endfunction

	task automatic apply_register(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
		case (idx)
			REG_FF0: ff0 = sext20(val);
			REG_FF1: ff1 = sext20(val);
			REG_FF2: ff2 = sext20(val);
			REG_FB1: fb1 = sext20(val);
			REG_FB2: fb2 = sext20(val);
			REG_STAGES: stage_count = val[7:0];
			default: ;
		endcase
	endtask

	// Run one sample through the active stages and queue the filtered result.
	task automatic filter_sample(logic [SAMPLE_BITS-1:0] s_in);
		longint smp, x0, acc, y, q;
		int unsigned n;
		filtered_t r;
		smp = s_in;
		r.clip = 1'b0;
		n = stage_count;
		if (n < 1) n = 1;
		if (n > STAGES) n = STAGES;
		for (int s = 0; s < n; s++) begin
			x0 = smp - 2048;
			acc = (ff0 * x0 + ff1 * x_tap1[s] + ff2 * x_tap2[s]) * (64'sd1 << ALIGN_SH)
				- fb1 * y_tap1[s] - fb2 * y_tap2[s];
			y = floor_shr(acc, 16);
			if (y > 8388607) begin y = 8388607; r.clip = 1'b1; end
			if (y < -8388608) begin y = -8388608; r.clip = 1'b1; end
			x_tap2[s] = x_tap1[s];
			x_tap1[s] = x0;
			y_tap2[s] = y_tap1[s];
			y_tap1[s] = y;
			q = floor_shr(y, ALIGN_SH) + 2048;
			if (q > 4095) begin q = 4095; r.clip = 1'b1; end
			if (q < 0) begin q = 0; r.clip = 1'b1; end
			smp = q;
		end
		r.sample = smp[SAMPLE_BITS-1:0];
		expected_filtered.push_back(r);
	endtask

	// Driver: present queued samples, with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid) filter_sample(sample_in);
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sample_in <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		filtered_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_filtered.size() == 0) begin
				$error("unexpected result sample_out=%0d", sample_out);
				failed = 1'b1;
			end else begin
				e = expected_filtered.pop_front();
				if (sample_out !== e.sample) begin
					$error("sample_out expected %0d actual %0d", e.sample, sample_out);
					failed = 1'b1;
				end
				if (clipped !== e.clip) begin
					$error("clipped expected %0d actual %0d", e.clip, clipped);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, val);
		cfg_valid <= 1'b0;
	endtask

	// Wait until the driver has handed over everything and all results are back.
	task automatic drain;
		do @(posedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_filtered.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_coefs(int a, int b, int c, int d, int e, int n);
		write_register(REG_FF0, a);
		write_register(REG_FF1, b);
		write_register(REG_FF2, c);
		write_register(REG_FB1, d);
		write_register(REG_FB2, e);
		write_register(REG_STAGES, n);
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++)
			pending_samples.push_back($urandom_range(4095));
	endtask

	initial begin
		ff0 = 46395; ff1 = -105181; ff2 = 65536; fb1 = -105181; fb2 = 46395;
		stage_count = 128;
		for (int s = 0; s < STAGES; s++) begin
			x_tap1[s] = 0; x_tap2[s] = 0; y_tap1[s] = 0; y_tap2[s] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: default settings with extremes and alternating bit patterns.
		foreach (pending_samples[i]) ;
		pending_samples.push_back(12'd2048);
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'd4095);
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'hAAA);
		pending_samples.push_back(12'h555);
		drain();
		// Heavy gain to force saturation of y and of the sample; stage count zero.
		load_coefs(524287, -524288, 524287, -524288, 524287, 0);
		pending_samples.push_back(12'd4095);
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'd4095);
		pending_samples.push_back(12'd2048);
		drain();
		// Stage count above the chain length; ignored register indexes.
		load_coefs(-524288, 0, 0, 524287, -524288, 255);
		write_register(3'd6, 32'h12345);
		write_register(3'd7, 32'hFFFFF);
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'd4095);
		pending_samples.push_back(12'd1);
		drain();

		// Random phases over several settings and idling mixes.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 74; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 74; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			case (ph)
				0: load_coefs(65536, 0, 0, 0, 0, 1);
				1: load_coefs(46395, -105181, 65536, -105181, 46395, 4);
				2: load_coefs($urandom_range(1048575), $urandom_range(1048575),
					$urandom_range(1048575), $urandom_range(1048575),
					$urandom_range(1048575), $urandom_range(1, 3));
				3: load_coefs(524287, 524287, 524287, -524288, -524288, 2);
				4: load_coefs(30000, 20000, 10000, -40000, 20000, $urandom_range(5, 16));
				5: load_coefs(-524288, -524288, -524288, 524287, 524287, 1);
				6: load_coefs($urandom_range(1048575), $urandom_range(1048575),
					$urandom_range(1048575), $urandom_range(1048575),
					$urandom_range(1048575), 128);
				default: load_coefs(46395, -105181, 65536, -105181, 46395,
					$urandom_range(1, 8));
			endcase
			queue_random(ph == 6 ? 50 : 270);
			drain();
		end

		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule
